>>> src/closest_strain_hamming_classifier_defines.svh
// Assertion macros shared by the classifier RTL.
// No dependencies; included by the files that check their own logic.
`ifndef CLOSEST_STRAIN_HAMMING_CLASSIFIER_DEFINES_SVH
`define CLOSEST_STRAIN_HAMMING_CLASSIFIER_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define CSHC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define CSHC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/cshc_pkg.sv
// Shared types, constants and helpers for the closest strain classifier.
// No dependencies; imported by every module of the block.
`default_nettype none

package cshc_pkg;

  localparam int MAX_STRAINS = 8;
  localparam int MAX_LOCI    = 1024;
  localparam int COUNT_BOUND = (MAX_LOCI < 2047) ? MAX_LOCI : 2047;

  localparam int BASE_W = 8;
  localparam int CNT_W  = 11;
  localparam int IDX_W  = $clog2(MAX_STRAINS);
  localparam int LANE_W = 4;
  localparam int CFG_IDX_W = 2;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_STRAINS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = CFG_IDX_W'(1);

  localparam logic [LANE_W-1:0] NUM_STRAINS_RST = LANE_W'(MAX_STRAINS);
  localparam logic [CNT_W-1:0]  THRESHOLD_RST   = CNT_W'(2);

  localparam logic [BASE_W-1:0] BASE_A = BASE_W'(8'h41);
  localparam logic [BASE_W-1:0] BASE_C = BASE_W'(8'h43);
  localparam logic [BASE_W-1:0] BASE_G = BASE_W'(8'h47);
  localparam logic [BASE_W-1:0] BASE_T = BASE_W'(8'h54);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(COUNT_BOUND);

  // Per-locus control fed to every lane
  typedef struct packed {
    logic acc;
    logic last;
    logic read_ok;
  } lane_ctl_t;

  // Configuration as seen by the merge stage
  typedef struct packed {
    logic [LANE_W-1:0] num_strains;
    logic [CNT_W-1:0]  threshold;
  } cfg_t;

  // Read totals captured on the last locus
  typedef struct packed {
    logic [MAX_STRAINS-1:0][CNT_W-1:0] counts;
    logic [CNT_W-1:0]                  amb;
    logic [CNT_W-1:0]                  vcnt;
  } snap_t;

  function automatic logic is_clear_base(input logic [BASE_W-1:0] b);
    return (b == BASE_A) || (b == BASE_C) || (b == BASE_G) || (b == BASE_T);
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v < CNT_MAX) ? (v + CNT_W'(1)) : CNT_MAX;
  endfunction

endpackage

`default_nettype wire

>>> src/closest_strain_hamming_classifier.sv
// Closest strain classifier: takes one locus per cycle while the input is not
// stalled, with no gap between loci or reads, all eight strain lanes counting
// mismatches in parallel. The totals of a read pass from the lane counters into
// the capture register as its last locus transfers, then through the min tree
// into the output register. The input stalls only while a captured read waits
// behind a stalled result. Configuration writes are always taken (cfg_ready high);
// write them only while no read is in flight. Depends on cshc_pkg,
// cshc_lane and cshc_merge.
`default_nettype none
`include "closest_strain_hamming_classifier_defines.svh"

module closest_strain_hamming_classifier (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [cshc_pkg::BASE_W-1:0]     in_read_base,
  input  wire logic [cshc_pkg::BASE_W-1:0]     in_ref_base_0,
  input  wire logic [cshc_pkg::BASE_W-1:0]     in_ref_base_1,
  input  wire logic [cshc_pkg::BASE_W-1:0]     in_ref_base_2,
  input  wire logic [cshc_pkg::BASE_W-1:0]     in_ref_base_3,
  input  wire logic [cshc_pkg::BASE_W-1:0]     in_ref_base_4,
  input  wire logic [cshc_pkg::BASE_W-1:0]     in_ref_base_5,
  input  wire logic [cshc_pkg::BASE_W-1:0]     in_ref_base_6,
  input  wire logic [cshc_pkg::BASE_W-1:0]     in_ref_base_7,
  input  wire logic                            in_last_locus,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [cshc_pkg::IDX_W-1:0]           out_closest_strain,
  output logic                                 out_recombinant,
  output logic [cshc_pkg::CNT_W-1:0]           out_best_distance,
  output logic [cshc_pkg::CNT_W-1:0]           out_ambiguous_count,
  output logic [cshc_pkg::CNT_W-1:0]           out_valid_count,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [cshc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cshc_pkg::CNT_W-1:0]      cfg_data
);
  import cshc_pkg::*;

  logic [BASE_W-1:0] ref_bases [MAX_STRAINS];
  logic [CNT_W-1:0]  lane_fin  [MAX_STRAINS];
  lane_ctl_t         ctl;
  logic              in_acc;
  logic              take;

  logic [CNT_W-1:0]  amb_r, amb_nxt, amb_fin;
  logic [CNT_W-1:0]  loci_r, loci_nxt, loci_fin;
  logic              snap_v_r, snap_v_nxt;
  snap_t             snap_r;
  cfg_t              cfg_r, cfg_nxt;

  assign ref_bases[0] = in_ref_base_0;
  assign ref_bases[1] = in_ref_base_1;
  assign ref_bases[2] = in_ref_base_2;
  assign ref_bases[3] = in_ref_base_3;
  assign ref_bases[4] = in_ref_base_4;
  assign ref_bases[5] = in_ref_base_5;
  assign ref_bases[6] = in_ref_base_6;
  assign ref_bases[7] = in_ref_base_7;

  // Hold input only while the capture register is full and cannot drain
  assign in_stall = snap_v_r && !take;
  assign in_acc   = in_valid && !in_stall;

  assign ctl = '{acc: in_acc, last: in_last_locus, read_ok: is_clear_base(in_read_base)};

  // Strain lanes
  for (genvar g = 0; g < MAX_STRAINS; g++) begin : g_lane
    cshc_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .read_base (in_read_base),
      .ref_base  (ref_bases[g]),
      .count_fin (lane_fin[g])
    );
  end

  // Read-wide tallies
  assign amb_fin  = ctl.read_ok ? amb_r : sat_inc(amb_r);
  assign loci_fin = sat_inc(loci_r);

  always_comb begin
    amb_nxt  = amb_r;
    loci_nxt = loci_r;
    if (in_acc) begin
      amb_nxt  = in_last_locus ? '0 : amb_fin;
      loci_nxt = in_last_locus ? '0 : loci_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amb_r  <= '0;
      loci_r <= '0;
    end else begin
      amb_r  <= amb_nxt;
      loci_r <= loci_nxt;
    end
  end

  // Capture read totals on the last locus; drop the flag once the merge stage takes it
  always_comb begin
    snap_v_nxt = snap_v_r;
    if (take) begin
      snap_v_nxt = 1'b0;
    end
    if (in_acc && in_last_locus) begin
      snap_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_v_r <= 1'b0;
    end else begin
      snap_v_r <= snap_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_last_locus) begin
      for (int i = 0; i < MAX_STRAINS; i++) begin
        snap_r.counts[i] <= lane_fin[i];
      end
      snap_r.amb  <= amb_fin;
      snap_r.vcnt <= (loci_fin >= amb_fin) ? (loci_fin - amb_fin) : '0;
    end
  end

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_NUM_STRAINS: cfg_nxt.num_strains = cfg_data[LANE_W-1:0];
        CFG_THRESHOLD:   cfg_nxt.threshold   = cfg_data;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_strains <= NUM_STRAINS_RST;
      cfg_r.threshold   <= THRESHOLD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cshc_merge u_merge (
    .clk                 (clk),
    .rst_n               (rst_n),
    .snap_valid          (snap_v_r),
    .snap                (snap_r),
    .cfg                 (cfg_r),
    .take                (take),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_closest_strain  (out_closest_strain),
    .out_recombinant     (out_recombinant),
    .out_best_distance   (out_best_distance),
    .out_ambiguous_count (out_ambiguous_count),
    .out_valid_count     (out_valid_count)
  );

  `CSHC_ASSERT_NEXT(a_capture_last, in_acc && in_last_locus,
    snap_v_r, "last locus transferred but totals not captured")
  `CSHC_ASSERT_NEXT(a_clear_after_read, in_acc && in_last_locus,
    (loci_r == '0) && (amb_r == '0), "read tallies not cleared after last locus")
  `CSHC_ASSERT_SAME(a_amb_le_loci, 1'b1,
    amb_r <= loci_r, "ambiguous tally exceeds loci seen")

endmodule

`default_nettype wire

>>> src/cshc_lane.sv
// One strain lane: mismatch counter against the read base.
// Depends on cshc_pkg.
`default_nettype none

module cshc_lane (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire cshc_pkg::lane_ctl_t       ctl,
  input  wire logic [cshc_pkg::BASE_W-1:0] read_base,
  input  wire logic [cshc_pkg::BASE_W-1:0] ref_base,
  output logic      [cshc_pkg::CNT_W-1:0]  count_fin
);
  import cshc_pkg::*;

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             hit;

  // Count a mismatch only where both bases are clear
  assign hit       = ctl.read_ok && is_clear_base(ref_base) && (read_base != ref_base);
  assign count_fin = hit ? sat_inc(cnt_r) : cnt_r;

  // Advance on each transfer, clear after the last locus
  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.acc) begin
      cnt_nxt = ctl.last ? '0 : count_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/cshc_merge.sv
// Merge stage: picks the lowest-index active lane with the fewest
// mismatches and holds the result in the output register. Depends on cshc_pkg.
`default_nettype none
`include "closest_strain_hamming_classifier_defines.svh"

module cshc_merge (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        snap_valid,
  input  wire cshc_pkg::snap_t             snap,
  input  wire cshc_pkg::cfg_t              cfg,
  output logic                             take,
  input  wire logic                        out_stall,
  output logic                             out_valid,
  output logic [cshc_pkg::IDX_W-1:0]       out_closest_strain,
  output logic                             out_recombinant,
  output logic [cshc_pkg::CNT_W-1:0]       out_best_distance,
  output logic [cshc_pkg::CNT_W-1:0]       out_ambiguous_count,
  output logic [cshc_pkg::CNT_W-1:0]       out_valid_count
);
  import cshc_pkg::*;

  logic [LANE_W-1:0] lanes;
  logic [CNT_W:0]    key0 [MAX_STRAINS];
  logic [CNT_W:0]    key1 [MAX_STRAINS/2];
  logic [IDX_W-1:0]  idx1 [MAX_STRAINS/2];
  logic [CNT_W:0]    key2 [MAX_STRAINS/4];
  logic [IDX_W-1:0]  idx2 [MAX_STRAINS/4];
  logic [CNT_W-1:0]  best;
  logic [IDX_W-1:0]  best_idx;

  logic              out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]  closest_r;
  logic              recomb_r;
  logic [CNT_W-1:0]  best_r, amb_r, vcnt_r;

  // Clamp the lane count to 1..MAX_STRAINS
  always_comb begin
    lanes = cfg.num_strains;
    if (cfg.num_strains == '0) begin
      lanes = LANE_W'(1);
    end else if (cfg.num_strains > LANE_W'(MAX_STRAINS)) begin
      lanes = LANE_W'(MAX_STRAINS);
    end
  end

  // Min tree; inactive lanes get the top key bit so they never win,
  // and a right branch wins only when strictly smaller
  always_comb begin
    for (int i = 0; i < MAX_STRAINS; i++) begin
      key0[i] = {(LANE_W'(i) >= lanes), snap.counts[i]};
    end
    for (int i = 0; i < MAX_STRAINS/2; i++) begin
      if (key0[2*i+1] < key0[2*i]) begin
        key1[i] = key0[2*i+1];
        idx1[i] = IDX_W'(2*i+1);
      end else begin
        key1[i] = key0[2*i];
        idx1[i] = IDX_W'(2*i);
      end
    end
    for (int i = 0; i < MAX_STRAINS/4; i++) begin
      if (key1[2*i+1] < key1[2*i]) begin
        key2[i] = key1[2*i+1];
        idx2[i] = idx1[2*i+1];
      end else begin
        key2[i] = key1[2*i];
        idx2[i] = idx1[2*i];
      end
    end
    if (key2[1] < key2[0]) begin
      best     = key2[1][CNT_W-1:0];
      best_idx = idx2[1];
    end else begin
      best     = key2[0][CNT_W-1:0];
      best_idx = idx2[0];
    end
  end

  // Output register frees when empty or when its result transfers
  assign take = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (take && snap_valid) begin
      closest_r <= best_idx;
      recomb_r  <= (best >= cfg.threshold);
      best_r    <= best;
      amb_r     <= snap.amb;
      vcnt_r    <= snap.vcnt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_closest_strain  = closest_r;
  assign out_recombinant     = recomb_r;
  assign out_best_distance   = best_r;
  assign out_ambiguous_count = amb_r;
  assign out_valid_count     = vcnt_r;

  `CSHC_ASSERT_SAME(a_closest_active, out_valid_r,
    ({1'b0, closest_r} < lanes), "closest strain is not an active lane")
  `CSHC_ASSERT_NEXT(a_load_result, snap_valid && take,
    out_valid_r, "snapshot taken but no result shown")

endmodule

`default_nettype wire
